/* hw/rtl/bounded_fifo_snapshot_top_macros.svh */
// Assertion macros shared by the RTL of the bounded FIFO snapshot block.
// Both forms sample on clk_i; the first is held off while rst_ni is low.
`ifndef BOUNDED_FIFO_SNAPSHOT_TOP_MACROS_SVH
`define BOUNDED_FIFO_SNAPSHOT_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BFS_ASSERT(lbl, prop, msg)

`define BFS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hw/rtl/bfs_pkg.sv */
`timescale 1ns / 1ps

package bfs_pkg;

  // storage geometry
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // fixed field widths
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned MAXC_W  = 5;

  localparam int unsigned STORE_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
  localparam int unsigned LIM_W   = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = MAXC_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_NEWEST = 1'b1;

  localparam logic [MAXC_W-1:0] MAX_COUNT_RESET = 5'd10;

  typedef struct packed {
    logic             clear_request;
    logic             add_valid;
    logic [VAL_W-1:0] add_value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   entry_value;
    logic [POS_W-1:0]   entry_position;
    logic [TOTAL_W-1:0] entry_total;
    logic               list_empty;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic load;
    logic read;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  // reduce a sum below 2*DEPTH into a slot index
  function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return PTR_W'(r);
  endfunction

endpackage

/* hw/rtl/bfs_ram.sv */
`timescale 1ns / 1ps

module bfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bfs_ctrl.sv */
`timescale 1ns / 1ps
`include "bounded_fifo_snapshot_top_macros.svh"

module bfs_ctrl import bfs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // fetch the oldest entry
        cmd_o.read = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            cmd_o.read    = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BFS_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input and output active together")
  `BFS_ASSERT(a_load_fetch, (in_valid_i && in_ready_o) |=> (cmd_o.read && !out_valid_o), "no fetch after load")
  `BFS_ASSERT(a_last_idle, (out_valid_o && out_ready_i && stat_i.last) |=> in_ready_o, "run end did not return to idle")

endmodule

/* hw/rtl/bfs_datapath.sv */
`timescale 1ns / 1ps
`include "bounded_fifo_snapshot_top_macros.svh"

module bfs_datapath import bfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_t                   in_data_i,
  output out_t                  out_data_o,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o
);

  logic [MAXC_W-1:0]  max_count_q;
  logic               discard_newest_q;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PTR_W-1:0]   pos_q;

  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   h0, h1;
  logic [PTR_W-1:0]   p0, p1;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [PTR_W-1:0]   rd_pos;
  logic [PTR_W-1:0]   rd_addr;
  logic [STORE_W-1:0] rd_data;
  logic               empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q      <= MAX_COUNT_RESET;
      discard_newest_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_COUNT:      max_count_q      <= cfg_wdata_i;
        REG_DISCARD_NEWEST: discard_newest_q <= cfg_wdata_i[0];
        default:            ;
      endcase
    end
  end

  // clear, append, then trim to the limit
  always_comb begin
    lim = (LIM_W'(max_count_q) > LIM_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(max_count_q);
    h0  = in_data_i.clear_request ? '0 : cnt_q;
    p0  = in_data_i.clear_request ? '0 : ptr_q;
    h1      = h0;
    p1      = p0;
    wr_en   = 1'b0;
    wr_addr = p0;
    if (cmd_i.load && in_data_i.add_valid) begin
      if (h0 == CNT_W'(DEPTH)) begin
        // full: overwrite the oldest unless the new value is the one dropped
        if (!discard_newest_q) begin
          wr_en = 1'b1;
          p1    = wrap_slot(SUM_W'(p0) + SUM_W'(1));
        end
      end else begin
        wr_en   = 1'b1;
        wr_addr = wrap_slot(SUM_W'(p0) + SUM_W'(h0));
        h1      = h0 + CNT_W'(1);
      end
    end
    cnt_d = h1;
    ptr_d = p1;
    if (h1 > lim) begin
      cnt_d = lim;
      if (!discard_newest_q) begin
        ptr_d = wrap_slot(SUM_W'(p1) + SUM_W'(h1 - lim));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else if (cmd_i.load) begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      pos_q <= '0;
    end else if (cmd_i.advance) begin
      pos_q <= pos_q + PTR_W'(1);
    end
  end

  assign rd_pos  = cmd_i.advance ? (pos_q + PTR_W'(1)) : pos_q;
  assign rd_addr = wrap_slot(SUM_W'(ptr_q) + SUM_W'(rd_pos));

  bfs_ram #(
    .WIDTH(STORE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (STORE_W'(in_data_i.add_value)),
    .re_i    (cmd_i.read),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign empty       = (cnt_q == '0);
  assign stat_o.last = empty || ((CNT_W'(pos_q) + CNT_W'(1)) == cnt_q);

  assign out_data_o.entry_value    = empty ? '0 : VAL_W'(rd_data);
  assign out_data_o.entry_position = POS_W'(pos_q);
  assign out_data_o.entry_total    = TOTAL_W'(cnt_q);
  assign out_data_o.list_empty     = empty;
  assign out_data_o.last_of_run    = stat_o.last;

  `BFS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "held count above depth")
  `BFS_ASSERT(a_ptr_bound, SUM_W'(ptr_q) < SUM_W'(DEPTH), "oldest pointer out of range")
  `BFS_ASSERT(a_pos_bound, empty || (CNT_W'(pos_q) < cnt_q), "read position past held count")

endmodule

/* hw/rtl/bounded_fifo_snapshot_top.sv */
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// -------   ----------------------   ---------------------------------
// input     in_valid_i / in_ready_o  in_data_i  (clear, add, value)
// output    out_valid_o / out_ready_i out_data_o (one entry per transaction)
// config    cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// An input transaction is accepted and the list updated, then the oldest entry is
// fetched from the store, then each held entry goes out in its own transaction;
// an empty list still emits one transaction. The single read port of the store
// sets the one-entry-per-cycle output rate while out_ready_i is high.
// Reset empties the list and loads max_count = 10, discard_newest = 0.
// A stalled output holds the current entry; input is taken only between runs.

module bounded_fifo_snapshot_top import bfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  bfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
